// ----- src/hva_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, codes and score helpers for the hmm viterbi aligner
// no dependencies; imported by the aligner and its checker
package hva_pkg;

  localparam int MAX_EMIT_STATES = 15;
  localparam int MAX_FEATURES    = 64;
  localparam int MAX_FRAMES      = 1024;
  localparam int FRACTION_BITS   = 16;

  typedef logic signed [47:0] score_t;

  localparam score_t SCORE_MAX = {1'b0, {47{1'b1}}};
  localparam score_t SCORE_MIN = {1'b1, {47{1'b0}}};
  localparam logic [31:0] BARRED_WORD = 32'h8000_0000;

  // request opcodes
  localparam logic [1:0] OP_TABLE  = 2'd0;
  localparam logic [1:0] OP_ELEM   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // table selects
  localparam logic [1:0] TBL_MEAN  = 2'd0;
  localparam logic [1:0] TBL_VAR   = 2'd1;
  localparam logic [1:0] TBL_GC    = 2'd2;
  localparam logic [1:0] TBL_TRANS = 2'd3;

  // result status and kind
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFR   = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;
  localparam logic       KIND_SCORE = 1'b0;
  localparam logic       KIND_PATH  = 1'b1;

  // register indexes
  localparam logic REG_STATES = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  // saturating score add, impossible stays impossible
  function automatic score_t add_score(score_t a, score_t b);
    logic signed [48:0] r;
    r = {a[47], a} + {b[47], b};
    if (a == SCORE_MIN || b == SCORE_MIN) return SCORE_MIN;
    if (r[48] != r[47]) return r[48] ? SCORE_MIN + 48'sd1 : SCORE_MAX;
    if (r[47:0] == SCORE_MIN) return SCORE_MIN + 48'sd1;
    return r[47:0];
  endfunction

  // transition word as score, barred word means impossible
  function automatic score_t trans_score(logic [31:0] w);
    if (w == BARRED_WORD) return SCORE_MIN;
    return {{16{w[31]}}, w};
  endfunction

endpackage

// ----- src/hva_ram.sv -----
`timescale 1ns / 1ps
// generic single write port ram with one registered read port
// no dependencies
module hva_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- src/hmm_viterbi_aligner.sv -----
`timescale 1ns / 1ps
// Viterbi aligner of feature frames to a left-to-right HMM with diagonal Gaussian states.
// Table writes and feature elements that do not complete a frame are accepted without a stall. A
// frame end runs a sequencer over all 15 state slots: for each active state, a max-plus
// predecessor search, then, if a predecessor is reachable, per element a shift-add square
// and a restoring divide by the variance, plus reads and accumulation. A finish runs an
// exit search and then a traceback over every frame; a path read fetches one stored state.
// The shared square/divide unit sets the frame time. Results wait in an output register.
// Depends on hva_pkg and hva_ram.
module hmm_viterbi_aligner (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // row_index, column_index, frame_index, data_value
  input  logic [3:0]  s_tuser,  // opcode, table_select
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // path_score, aligned_state, status
  output logic        m_tuser,  // result_kind
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hva_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0,  S_STATE = 4'd1,  S_SRD = 4'd2,   S_SEV = 4'd3;
  localparam logic [3:0] S_ERD  = 4'd4,  S_ESQ   = 4'd5,  S_SQ = 4'd6,    S_DIV = 4'd7;
  localparam logic [3:0] S_ACC  = 4'd8,  S_EMF   = 4'd9,  S_WR = 4'd10,   S_TBR = 4'd11;
  localparam logic [3:0] S_TBE  = 4'd12, S_PRW   = 4'd13, S_PRG = 4'd14,  S_OUT = 4'd15;

  // request fields
  logic [1:0]  op, sel;
  logic [4:0]  row;
  logic [5:0]  col;
  logic [9:0]  fidx;
  logic [31:0] val;
  assign op   = s_tuser[1:0];
  assign sel  = s_tuser[3:2];
  assign row  = s_tdata[4:0];
  assign col  = s_tdata[10:5];
  assign fidx = s_tdata[20:11];
  assign val  = s_tdata[52:21];

  // control state
  logic [3:0]  state;
  logic [3:0]  n_reg;
  logic [6:0]  len_reg;
  logic [10:0] fs;
  logic        trunc, closed, bank;

  // sequencer payload
  logic [3:0]  s_idx, p_idx, arg, st;
  logic [4:0]  dst;
  logic [9:0]  t_cur, rd_idx;
  logic [10:0] tcnt;
  logic [5:0]  i_idx;
  logic [6:0]  cnt;
  logic        fin;
  score_t      best, sum, cur;
  logic [32:0] mand, mplr;
  logic [64:0] acc;
  logic [30:0] rem, vdiv;
  logic        o_kind;
  score_t      o_score;
  logic [3:0]  o_state;
  logic [1:0]  o_status;

  // effective register values
  logic [3:0] n_e;
  logic [6:0] len_e;
  assign n_e   = (n_reg == 4'd0) ? 4'd1 : n_reg;
  assign len_e = (len_reg == 7'd0) ? 7'd1 :
                 (len_reg > 7'(MAX_FEATURES)) ? 7'(MAX_FEATURES) : len_reg;

  logic acc_in;
  assign acc_in   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);

  // memories
  logic        mean_we, var_we, gc_we, tr_we, fb_we, sc_we, bp_we, bpth_we;
  logic [31:0] mean_rd, var_rd, gc_rd, tr_rd, fb_rd;
  logic [47:0] sc_rd;
  logic [3:0]  bp_rd, bpth_rd;
  logic [10:0] tm1;
  logic        row_ok;

  assign row_ok  = (row >= 5'd1) && (row <= 5'(MAX_EMIT_STATES));
  assign mean_we = acc_in && op == OP_TABLE && sel == TBL_MEAN && row_ok;
  assign var_we  = acc_in && op == OP_TABLE && sel == TBL_VAR && row_ok;
  assign gc_we   = acc_in && op == OP_TABLE && sel == TBL_GC && row_ok;
  assign tr_we   = acc_in && op == OP_TABLE && sel == TBL_TRANS &&
                   row < 5'(MAX_EMIT_STATES + 2) && col < 6'(MAX_EMIT_STATES + 2);
  assign fb_we   = acc_in && op == OP_ELEM && {1'b0, col} < len_e;
  assign sc_we   = (state == S_WR);
  assign bp_we   = (state == S_WR);
  assign bpth_we = (state == S_TBR);
  assign tm1     = tcnt - 11'd1;

  hva_ram #(.WIDTH(32), .DEPTH(1024)) u_mean (
    .clk, .we(mean_we), .waddr({row[3:0] - 4'd1, col}), .wdata(val),
    .raddr({s_idx - 4'd1, i_idx}), .rdata(mean_rd));
  hva_ram #(.WIDTH(32), .DEPTH(1024)) u_var (
    .clk, .we(var_we), .waddr({row[3:0] - 4'd1, col}), .wdata(val),
    .raddr({s_idx - 4'd1, i_idx}), .rdata(var_rd));
  hva_ram #(.WIDTH(32), .DEPTH(16)) u_gc (
    .clk, .we(gc_we), .waddr(row[3:0] - 4'd1), .wdata(val),
    .raddr(s_idx - 4'd1), .rdata(gc_rd));
  hva_ram #(.WIDTH(32), .DEPTH(1024)) u_trans (
    .clk, .we(tr_we), .waddr({row, col[4:0]}), .wdata(val),
    .raddr({1'b0, p_idx, dst}), .rdata(tr_rd));
  hva_ram #(.WIDTH(32), .DEPTH(64)) u_frame (
    .clk, .we(fb_we), .waddr(col), .wdata(val), .raddr(i_idx), .rdata(fb_rd));
  hva_ram #(.WIDTH(48), .DEPTH(32)) u_score (
    .clk, .we(sc_we), .waddr({~bank, s_idx - 4'd1}), .wdata(cur),
    .raddr({bank, p_idx - 4'd1}), .rdata(sc_rd));
  hva_ram #(.WIDTH(4), .DEPTH(16384)) u_bp (
    .clk, .we(bp_we), .waddr({t_cur, s_idx - 4'd1}), .wdata(arg),
    .raddr({tm1[9:0], st - 4'd1}), .rdata(bp_rd));
  hva_ram #(.WIDTH(4), .DEPTH(1024)) u_path (
    .clk, .we(bpth_we), .waddr(tm1[9:0]), .wdata(st),
    .raddr(rd_idx), .rdata(bpth_rd));

  // predecessor search step
  logic   first_t, start_zero, srch_first, srch_last, take;
  score_t cand, best_next;
  logic [3:0] arg_next;
  assign first_t    = (t_cur == 10'd0) && !fin;
  assign start_zero = first_t;
  assign cand       = first_t ? trans_score(tr_rd) : add_score(trans_score(tr_rd), sc_rd);
  assign srch_first = start_zero ? 1'b1 : (p_idx == 4'd1);
  assign srch_last  = start_zero || (p_idx == n_e);
  assign take       = srch_first || (cand > best);
  assign best_next  = take ? cand : best;
  assign arg_next   = take ? p_idx : arg;

  // element distance terms
  logic signed [32:0] diff;
  logic [32:0] ad;
  assign diff = {fb_rd[31], fb_rd} - {mean_rd[31], mean_rd};
  assign ad   = diff[32] ? 33'(-diff) : 33'(diff);

  // shared square and divide unit
  logic [31:0] rem_sh;
  logic        qbit;
  assign rem_sh = {rem, acc[64]};
  assign qbit   = rem_sh >= {1'b0, vdiv};

  // accumulation and emission
  score_t qsat, sum_next, em;
  logic signed [48:0] s49, neg;
  assign qsat     = (|acc[64:47]) ? SCORE_MAX : {1'b0, acc[46:0]};
  assign s49      = {sum[47], sum} + {qsat[47], qsat};
  assign sum_next = (s49[48] != s49[47]) ? SCORE_MAX : s49[47:0];
  assign neg      = -{sum[47], sum};
  assign em       = 48'(neg >>> 1);

  // configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_STATES) ? {28'd0, n_reg} : {25'd0, len_reg};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      n_reg   <= 4'd3;
      len_reg <= 7'd36;
      fs      <= 11'd0;
      trunc   <= 1'b0;
      closed  <= 1'b1;
      bank    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_STATES) n_reg <= pwdata[3:0];
        else len_reg <= pwdata[6:0];
      end
      case (state)
        S_IDLE: begin
          if (acc_in) begin
            case (op)
              OP_ELEM: begin
                if ({1'b0, col} == len_e - 7'd1) begin
                  if (closed) begin
                    closed <= 1'b0;
                    trunc  <= 1'b0;
                    fs     <= 11'd0;
                  end
                  if (!closed && fs[10]) begin
                    trunc <= 1'b1;
                  end else begin
                    t_cur <= closed ? 10'd0 : fs[9:0];
                    s_idx <= 4'd1;
                    fin   <= 1'b0;
                    state <= S_STATE;
                  end
                end
              end
              OP_FINISH: begin
                if (fs == 11'd0) begin
                  closed   <= 1'b1;
                  o_kind   <= KIND_SCORE;
                  o_score  <= SCORE_MIN;
                  o_state  <= 4'd0;
                  o_status <= ST_NOFR;
                  state    <= S_OUT;
                end else begin
                  fin   <= 1'b1;
                  dst   <= {1'b0, n_e} + 5'd1;
                  p_idx <= 4'd1;
                  state <= S_SRD;
                end
              end
              OP_READ: begin
                rd_idx  <= fidx;
                o_kind  <= KIND_PATH;
                o_score <= '0;
                o_state <= 4'd0;
                if (closed && fs == 11'd0) begin
                  o_status <= ST_NOFR;
                  state    <= S_OUT;
                end else if (!closed || {1'b0, fidx} >= fs) begin
                  o_status <= ST_RANGE;
                  state    <= S_OUT;
                end else begin
                  state <= S_PRW;
                end
              end
              default: ;
            endcase
          end
        end
        S_STATE: begin
          if (s_idx > n_e) begin
            cur   <= SCORE_MIN;
            arg   <= (t_cur == 10'd0) ? 4'd0 : 4'd1;
            state <= S_WR;
          end else begin
            dst   <= {1'b0, s_idx};
            p_idx <= (t_cur == 10'd0) ? 4'd0 : 4'd1;
            state <= S_SRD;
          end
        end
        S_SRD: state <= S_SEV;
        S_SEV: begin
          best <= best_next;
          arg  <= arg_next;
          if (!srch_last) begin
            p_idx <= p_idx + 4'd1;
            state <= S_SRD;
          end else if (fin) begin
            closed   <= 1'b1;
            o_kind   <= KIND_SCORE;
            o_score  <= best_next;
            o_state  <= arg_next;
            o_status <= trunc ? ST_TRUNC : ST_OK;
            st       <= arg_next;
            tcnt     <= fs;
            state    <= S_TBR;
          end else if (best_next == SCORE_MIN) begin
            cur   <= SCORE_MIN;
            state <= S_WR;
          end else begin
            sum   <= {{16{gc_rd[31]}}, gc_rd};
            i_idx <= 6'd0;
            state <= S_ERD;
          end
        end
        S_ERD: state <= S_ESQ;
        S_ESQ: begin
          mand  <= ad;
          mplr  <= ad;
          acc   <= '0;
          cnt   <= 7'd0;
          vdiv  <= (var_rd[31] || var_rd == 32'd0) ? 31'd1 : var_rd[30:0];
          state <= S_SQ;
        end
        S_SQ: begin
          acc  <= {acc[63:0], 1'b0} + (mplr[32] ? {32'd0, mand} : 65'd0);
          mplr <= {mplr[31:0], 1'b0};
          cnt  <= cnt + 7'd1;
          if (cnt == 7'd32) begin
            cnt   <= 7'd0;
            rem   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= qbit ? 31'(rem_sh - {1'b0, vdiv}) : rem_sh[30:0];
          acc <= {acc[63:0], qbit};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd64) state <= S_ACC;
        end
        S_ACC: begin
          sum <= sum_next;
          if ({1'b0, i_idx} == len_e - 7'd1) begin
            state <= S_EMF;
          end else begin
            i_idx <= i_idx + 6'd1;
            state <= S_ERD;
          end
        end
        S_EMF: begin
          cur   <= add_score(best, em);
          state <= S_WR;
        end
        S_WR: begin
          if (s_idx == 4'(MAX_EMIT_STATES)) begin
            bank  <= ~bank;
            fs    <= {1'b0, t_cur} + 11'd1;
            state <= S_IDLE;
          end else begin
            s_idx <= s_idx + 4'd1;
            state <= S_STATE;
          end
        end
        S_TBR: state <= S_TBE;
        S_TBE: begin
          st <= (bp_rd == 4'd0) ? 4'd1 : bp_rd;
          if (tcnt == 11'd1) state <= S_OUT;
          else begin
            tcnt  <= tm1;
            state <= S_TBR;
          end
        end
        S_PRW: state <= S_PRG;
        S_PRG: begin
          o_state  <= bpth_rd;
          o_status <= ST_OK;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result port
  assign m_tvalid = (state == S_OUT);
  assign m_tuser  = o_kind;
  assign m_tdata  = {2'd0, o_status, o_state, o_score};

endmodule

// ----- src/hva_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the hmm viterbi aligner, bound to the top level
// depends on hva_pkg
module hva_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [55:0] s_tdata,
  input logic [3:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tuser
);
  import hva_pkg::*;

  // a pending result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // no request taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request taken while result pending");

  // table writes do not stall the block
  a_tbl: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[1:0] == OP_TABLE |=> s_tready)
    else $error("table write stalled the block");

  // finish and path read always take the block out of idle
  a_ans: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[1:0] == OP_FINISH || s_tuser[1:0] == OP_READ)
    |=> !s_tready)
    else $error("finish or read gave no result");

  // an empty segment reports state zero
  a_nofr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[53:52] == ST_NOFR |-> m_tdata[51:48] == 4'd0)
    else $error("no-frame result with nonzero state");

endmodule

bind hmm_viterbi_aligner hva_checker u_hva_checker (.*);
